// ===== rtl/kmt_pkg.sv =====
// Shared types and constants for the killer move table and reorder block.
package kmt_pkg;

   // Fixed field widths
   localparam int CMD_W   = 3;
   localparam int DEPTH_W = 7;
   localparam int POS_W   = 8;
   localparam int WORD_W  = 32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SAVE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   // One move list entry
   typedef struct packed {
      logic        [WORD_W-1:0] move;
      logic signed [WORD_W-1:0] score;
   } entry_type;

   // One killer slot pair
   typedef struct packed {
      logic [WORD_W-1:0] second;
      logic [WORD_W-1:0] first;
   } killer_type;

endpackage

// ===== rtl/kmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/killer_move_table_and_reorder_top.sv =====
// Top level: killer move table, move list and the reorder sequencer.
//
// Command port: a request is taken on a rising edge with start high and busy
// low; busy stays high until the request is finished. Each request yields one
// response, shown on the rsp_ ports for a single cycle with rsp_valid high,
// in the cycle in which busy falls. The receiver cannot stall; the response
// must be taken in that cycle.
// A clear zeroes one killer pair per cycle until all MAX_DEPTH pairs are zero.
// Insert time is set by the single move list port pair: the search looks at
// one entry per cycle and the shift moves one entry per cycle, once for each
// killer. Requests are handled one at a time.
// After reset the killer memory is zeroed by a pass over all MAX_DEPTH pairs,
// during which busy is high; no response is produced for it. Move list
// entries hold no defined value until written.
module killer_move_table_and_reorder_top
   import kmt_pkg::*;
#(
   parameter int MAX_DEPTH = 128,
   parameter int LIST_SIZE = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [DEPTH_W-1:0]       req_depth,
   input  logic [POS_W-1:0]         req_position,
   input  logic [POS_W-1:0]         req_start_position,
   input  logic [POS_W-1:0]         req_list_end,
   input  logic [WORD_W-1:0]        req_move_value,
   input  logic signed [WORD_W-1:0] req_score_value,
   output logic                     rsp_valid,
   output logic [WORD_W-1:0]        rsp_move_out,
   output logic signed [WORD_W-1:0] rsp_score_out,
   output logic                     rsp_first_found,
   output logic                     rsp_second_found
);

   localparam int DW  = $clog2(MAX_DEPTH);
   localparam int DCW = ((DW > DEPTH_W) ? DW : DEPTH_W) + 1;
   localparam int LW  = $clog2(LIST_SIZE);
   localparam int PW  = POS_W + 1;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLR   = 4'd1;
   localparam logic [3:0] ST_SAVE  = 4'd2;
   localparam logic [3:0] ST_READ  = 4'd3;
   localparam logic [3:0] ST_INS   = 4'd4;
   localparam logic [3:0] ST_SEEK  = 4'd5;
   localparam logic [3:0] ST_SRCH  = 4'd6;
   localparam logic [3:0] ST_SHIFT = 4'd7;
   localparam logic [3:0] ST_PLACE = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic              boot_ff, boot_in;
   logic [DW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     didx_ff, didx_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [PW-1:0]     limit_ff, limit_in;
   logic [PW-1:0]     from_ff, from_in;
   logic [PW-1:0]     cur_ff, cur_in;
   logic              phase_ff, phase_in;
   logic [WORD_W-1:0] k1_ff, k1_in;
   logic [WORD_W-1:0] k2_ff, k2_in;
   entry_type         keep_ff, keep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] res_move_ff, res_move_in;
   logic [WORD_W-1:0] res_score_ff, res_score_in;
   logic              res_first_ff, res_first_in;
   logic              res_second_ff, res_second_in;

   // memory ports
   logic          list_we, list_re;
   logic [LW-1:0] list_wa, list_ra;
   entry_type     list_wd, list_rd;
   logic          kill_we, kill_re;
   logic [DW-1:0] kill_wa, kill_ra;
   killer_type    kill_wd, kill_rd;

   // request decode
   logic [DCW-1:0] depth_ext;
   logic           depth_ok;
   logic           pos_ok;
   logic [PW-1:0]  req_limit;
   logic           accept;

   // shared compare unit
   logic [WORD_W-1:0] cmp_b;
   logic              cmp_eq;

   assign depth_ext = DCW'(req_depth);
   assign depth_ok  = depth_ext < DCW'(MAX_DEPTH);
   assign pos_ok    = {1'b0, req_position} < PW'(LIST_SIZE);
   assign req_limit = ({1'b0, req_list_end} < PW'(LIST_SIZE)) ?
                      {1'b0, req_list_end} : PW'(LIST_SIZE);
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;

   // one comparator: killer slot one on save, current target during search
   assign cmp_b  = (state_ff == ST_SAVE) ? kill_rd.first : (phase_ff ? k2_ff : k1_ff);
   assign cmp_eq = (list_rd.move == cmp_b);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      boot_in       = boot_ff;
      cnt_in        = cnt_ff;
      didx_in       = didx_ff;
      start_in      = start_ff;
      limit_in      = limit_ff;
      from_in       = from_ff;
      cur_in        = cur_ff;
      phase_in      = phase_ff;
      k1_in         = k1_ff;
      k2_in         = k2_ff;
      keep_in       = keep_ff;
      rsp_valid_in  = 1'b0;
      res_move_in   = res_move_ff;
      res_score_in  = res_score_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      list_we       = 1'b0;
      list_wa       = cur_ff[LW-1:0];
      list_wd       = list_rd;
      list_re       = 1'b0;
      list_ra       = req_position[LW-1:0];
      kill_we       = 1'b0;
      kill_wa       = cnt_ff;
      kill_wd       = '0;
      kill_re       = 1'b0;
      kill_ra       = depth_ext[DW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_move_in   = '0;
               res_score_in  = '0;
               res_first_in  = 1'b0;
               res_second_in = 1'b0;
               didx_in       = depth_ext[DW-1:0];
               start_in      = req_start_position;
               limit_in      = req_limit;
               state_in      = ST_DONE;
               case (req_command)
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLR;
                  end
                  CMD_SAVE: begin
                     if (depth_ok && pos_ok) begin
                        kill_re  = 1'b1;
                        list_re  = 1'b1;
                        state_in = ST_SAVE;
                     end
                  end
                  CMD_WRITE: begin
                     if (pos_ok) begin
                        list_we       = 1'b1;
                        list_wa       = req_position[LW-1:0];
                        list_wd.move  = req_move_value;
                        list_wd.score = req_score_value;
                     end
                  end
                  CMD_INSERT: begin
                     if (depth_ok) begin
                        kill_re  = 1'b1;
                        state_in = ST_INS;
                     end
                  end
                  CMD_READ: begin
                     if (pos_ok) begin
                        list_re  = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // zero one killer pair per cycle
         ST_CLR: begin
            kill_we = 1'b1;
            kill_wa = cnt_ff;
            kill_wd = '0;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DW'(MAX_DEPTH - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end

         // killer pair and list entry are on the read ports
         ST_SAVE: begin
            if (!cmp_eq) begin
               kill_we        = 1'b1;
               kill_wa        = didx_ff;
               kill_wd.second = kill_rd.first;
               kill_wd.first  = list_rd.move;
            end
            state_in = ST_DONE;
         end

         ST_READ: begin
            res_move_in  = list_rd.move;
            res_score_in = list_rd.score;
            state_in     = ST_DONE;
         end

         // latch both killers, then search for killer one
         ST_INS: begin
            k1_in    = kill_rd.first;
            k2_in    = kill_rd.second;
            phase_in = 1'b0;
            from_in  = {1'b0, start_ff};
            state_in = ST_SEEK;
         end

         // open a search pass at from_ff
         ST_SEEK: begin
            if (from_ff >= limit_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  from_in  = from_ff + 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               list_re  = 1'b1;
               list_ra  = from_ff[LW-1:0];
               cur_in   = from_ff;
               state_in = ST_SRCH;
            end
         end

         // entry cur_ff is on the read port; on a miss, fetch the next one meanwhile
         ST_SRCH: begin
            if (cmp_eq) begin
               keep_in = list_rd;
               if (phase_ff) begin
                  res_second_in = 1'b1;
               end else begin
                  res_first_in = 1'b1;
               end
               if (cur_ff == from_ff) begin
                  state_in = ST_PLACE;
               end else begin
                  list_re  = 1'b1;
                  list_ra  = LW'(cur_ff - 1'b1);
                  state_in = ST_SHIFT;
               end
            end else if ((cur_ff + 1'b1) >= limit_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  from_in  = from_ff + 1'b1;
                  state_in = ST_SEEK;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               list_re = 1'b1;
               list_ra = LW'(cur_ff + 1'b1);
               cur_in  = cur_ff + 1'b1;
            end
         end

         // entry cur_ff-1 is on the read port; it moves up to cur_ff
         ST_SHIFT: begin
            list_we = 1'b1;
            list_wa = cur_ff[LW-1:0];
            list_wd = list_rd;
            if ((cur_ff - 1'b1) == from_ff) begin
               state_in = ST_PLACE;
            end else begin
               list_re = 1'b1;
               list_ra = LW'(cur_ff - 2'd2);
               cur_in  = cur_ff - 1'b1;
            end
         end

         // the found entry goes to the front of the pass
         ST_PLACE: begin
            list_we = 1'b1;
            list_wa = from_ff[LW-1:0];
            list_wd = keep_ff;
            if (!phase_ff) begin
               phase_in = 1'b1;
               from_in  = from_ff + 1'b1;
               state_in = ST_SEEK;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         boot_ff      <= 1'b1;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      didx_ff       <= didx_in;
      start_ff      <= start_in;
      limit_ff      <= limit_in;
      from_ff       <= from_in;
      cur_ff        <= cur_in;
      k1_ff         <= k1_in;
      k2_ff         <= k2_in;
      keep_ff       <= keep_in;
      res_move_ff   <= res_move_in;
      res_score_ff  <= res_score_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
   end

   // move list memory
   kmt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (LIST_SIZE)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_wa),
      .wr_data (list_wd),
      .rd_en   (list_re),
      .rd_addr (list_ra),
      .rd_data (list_rd)
   );

   // killer pair memory
   kmt_ram #(
      .WIDTH ($bits(killer_type)),
      .DEPTH (MAX_DEPTH)
   ) u_killer_ram (
      .clock   (clock),
      .wr_en   (kill_we),
      .wr_addr (kill_wa),
      .wr_data (kill_wd),
      .rd_en   (kill_re),
      .rd_addr (kill_ra),
      .rd_data (kill_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_move_out     = res_move_ff;
   assign rsp_score_out    = res_score_ff;
   assign rsp_first_found  = res_first_ff;
   assign rsp_second_found = res_second_ff;

   // checks
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("response shown while sequencer active");

   a_srch_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH) |-> (cur_ff < limit_ff))
      else $error("search pointer beyond list bound");

endmodule
